FILE: rtl/crd_pkg.sv
package crd_pkg;

    localparam int STAMP_W    = 32;
    localparam int DEBOUNCE_W = 16;
    localparam int GAP_W      = 15;
    localparam int ALU_W      = 34;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int GAP_REGS   = 3;
    localparam int STATE_W    = 3;

    typedef logic [ALU_W-1:0]   t_alu_word;
    typedef logic [STAMP_W-1:0] t_stamp;
    typedef logic [GAP_W-1:0]   t_gap;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLACK_0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLACK_1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SLACK_2  = 3'd6;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd100;
    localparam t_gap                  TARGET_RST   = 15'd400;
    localparam t_gap                  SLACK_RST    = 15'd150;

    localparam logic [STATE_W-1:0] ST_IDLE = 3'd0;
    localparam logic [STATE_W-1:0] ST_DEB  = 3'd1;
    localparam logic [STATE_W-1:0] ST_DIFF = 3'd2;
    localparam logic [STATE_W-1:0] ST_DEV  = 3'd3;
    localparam logic [STATE_W-1:0] ST_TOL  = 3'd4;
    localparam logic [STATE_W-1:0] ST_OUT  = 3'd5;

endpackage

FILE: rtl/crd_alu.sv
module crd_alu (
    input  crd_pkg::t_alu_word i_a,
    input  crd_pkg::t_alu_word i_b,
    input  logic               i_sub,
    output crd_pkg::t_alu_word o_res
);
    import crd_pkg::*;

    t_alu_word w_b;

    assign w_b   = i_sub ? ~i_b : i_b;
    assign o_res = i_a + w_b + {{(ALU_W-1){1'b0}}, i_sub};

endmodule

FILE: rtl/clap_rhythm_detector.sv
// An accepted edge passes the debounce check, then (unless rejected) per interval the
// difference, deviation and tolerance steps; the one shared 34-bit adder takes three
// passes per interval. No new transaction is taken until its result is out of ST_OUT.
// Reset (synchronous, active low): stamp ring reads as zero, head slot zero,
// relay high, registers at 100/400/150/400/150/400/150, output empty.
module clap_rhythm_detector #(
    parameter int RING_DEPTH = 16,
    parameter int NUM_GAPS   = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [crd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [crd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [crd_pkg::STAMP_W-1:0]         i_edge_time_ms,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_relay_on,
    output logic                                o_edge_taken,
    output logic                                o_pattern_hit
);
    import crd_pkg::*;

    localparam int HW = $clog2(RING_DEPTH);
    localparam logic [HW-1:0] LAST_SLOT = HW'(RING_DEPTH - 1);
    localparam logic [1:0]    LAST_GAP  = 2'(NUM_GAPS - 1);

    logic [DEBOUNCE_W-1:0] r_debounce;
    t_gap                  r_target [GAP_REGS];
    t_gap                  r_slack  [GAP_REGS];

    t_stamp                r_ring [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_vld;
    t_stamp                r_rd;
    logic                  r_rdv;

    logic [STATE_W-1:0]    r_state;
    logic [HW-1:0]         r_head;
    logic [HW-1:0]         r_idx;
    logic [1:0]            r_gap;
    t_stamp                r_t;
    t_stamp                r_newer;
    t_stamp                r_udiff;
    t_alu_word             r_dev;
    logic                  r_relay;
    logic                  r_taken;
    logic                  r_hit;
    logic                  r_ovalid;
    logic                  r_orelay;
    logic                  r_otaken;
    logic                  r_ohit;

    logic [HW-1:0]         n_head;
    logic [HW-1:0]         w_prev_idx;
    logic [HW-1:0]         w_raddr;
    logic                  w_wen;
    t_stamp                w_stamp;
    t_alu_word             w_a;
    t_alu_word             w_b;
    logic                  w_sub;
    t_alu_word             w_res;
    logic                  w_range_ok;

    assign n_head     = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
    assign w_prev_idx = (r_idx == '0) ? LAST_SLOT : r_idx - 1'b1;
    assign w_stamp    = r_rdv ? r_rd : '0;
    assign w_range_ok = w_res[STAMP_W-1] || (w_res[STAMP_W-2:GAP_W] == '0);
    assign w_wen      = (r_state == ST_DEB) && (w_res[STAMP_W-1:0] >= STAMP_W'(r_debounce));

    always_comb begin
        w_raddr = r_idx;
        if (r_state == ST_IDLE || r_state == ST_DEB) begin
            w_raddr = r_head;
        end else if (r_state == ST_TOL) begin
            w_raddr = w_prev_idx;
        end
    end

    always_comb begin
        w_a   = {2'b00, r_t};
        w_b   = {2'b00, w_stamp};
        w_sub = 1'b1;
        unique case (r_state)
            ST_DIFF: begin
                w_a = {2'b00, r_newer};
                w_b = {2'b00, w_stamp};
            end
            ST_DEV: begin
                w_a = {{(ALU_W-STAMP_W){r_udiff[STAMP_W-1]}}, r_udiff};
                w_b = {{(ALU_W-GAP_W){1'b0}}, r_target[r_gap]};
            end
            ST_TOL: begin
                w_a   = {{(ALU_W-GAP_W){1'b0}}, r_slack[r_gap]};
                w_b   = r_dev;
                w_sub = ~r_dev[ALU_W-1];
            end
            default: begin
            end
        endcase
    end

    crd_alu u_alu (
        .i_a   (w_a),
        .i_b   (w_b),
        .i_sub (w_sub),
        .o_res (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (w_wen) begin
            r_ring[n_head] <= r_t;
        end
        r_rd  <= r_ring[w_raddr];
        r_rdv <= r_vld[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RST;
            for (int k = 0; k < GAP_REGS; k++) begin
                r_target[k] <= TARGET_RST;
                r_slack[k]  <= SLACK_RST;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEBOUNCE: r_debounce  <= i_cfg_data;
                REG_TARGET_0: r_target[0] <= i_cfg_data[GAP_W-1:0];
                REG_SLACK_0:  r_slack[0]  <= i_cfg_data[GAP_W-1:0];
                REG_TARGET_1: r_target[1] <= i_cfg_data[GAP_W-1:0];
                REG_SLACK_1:  r_slack[1]  <= i_cfg_data[GAP_W-1:0];
                REG_TARGET_2: r_target[2] <= i_cfg_data[GAP_W-1:0];
                REG_SLACK_2:  r_slack[2]  <= i_cfg_data[GAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= '0;
            r_vld    <= '0;
            r_relay  <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall && r_state != ST_OUT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_t     <= i_edge_time_ms;
                        r_state <= ST_DEB;
                    end
                end
                ST_DEB: begin
                    r_taken <= w_wen;
                    r_hit   <= 1'b0;
                    r_newer <= r_t;
                    r_idx   <= r_head;
                    r_gap   <= '0;
                    if (w_wen) begin
                        r_head         <= n_head;
                        r_vld[n_head]  <= 1'b1;
                        r_state        <= ST_DIFF;
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                ST_DIFF: begin
                    r_udiff <= w_res[STAMP_W-1:0];
                    if (r_newer == '0 || !w_range_ok) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_newer <= w_stamp;
                        r_state <= ST_DEV;
                    end
                end
                ST_DEV: begin
                    r_dev   <= w_res;
                    r_state <= ST_TOL;
                end
                ST_TOL: begin
                    if (w_res[ALU_W-1]) begin
                        r_state <= ST_OUT;
                    end else if (r_gap == LAST_GAP) begin
                        r_hit   <= 1'b1;
                        r_relay <= ~r_relay;
                        r_vld   <= '0;
                        r_head  <= '0;
                        r_state <= ST_OUT;
                    end else begin
                        r_gap   <= r_gap + 1'b1;
                        r_idx   <= w_prev_idx;
                        r_state <= ST_DIFF;
                    end
                end
                ST_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_orelay <= r_relay;
                        r_otaken <= r_taken;
                        r_ohit   <= r_hit;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = r_ovalid;
    assign o_relay_on    = r_orelay;
    assign o_edge_taken  = r_otaken;
    assign o_pattern_hit = r_ohit;

endmodule
